[sv/asl_pkg.sv]
// ----------------------------------------------------------------------------
// asl_pkg
// Shared types and constants for the adaptive speed low-pass filter.
// ----------------------------------------------------------------------------
package asl_pkg;

    localparam int unsigned SAMPLE_WIDTH_DEF = 16;
    localparam logic [31:0] TWO_PI_Q16       = 32'd411775;
    localparam int unsigned PT_SHIFT         = 7;
    localparam int unsigned K_SHIFT          = 16;

    localparam logic [2:0] REG_MIN_FREQ     = 3'd0;
    localparam logic [2:0] REG_MAX_FREQ     = 3'd1;
    localparam logic [2:0] REG_INV_BETA     = 3'd2;
    localparam logic [2:0] REG_SAMPLE_RATE  = 3'd3;
    localparam logic [2:0] REG_DERIV_CUTOFF = 3'd4;
    localparam logic [2:0] REG_MAX_SLEW     = 3'd5;
    localparam logic [2:0] REG_INIT_VALUE   = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_LIM,
        ST_LIMIT,
        ST_DIV_KD,
        ST_DERIV1,
        ST_DERIV2,
        ST_DX,
        ST_DIV_F,
        ST_DIV_KM,
        ST_MAIN1,
        ST_MAIN2,
        ST_OUT
    } state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_START_LIM,
        OP_LIMIT,
        OP_START_KD,
        OP_DERIV1,
        OP_DERIV2,
        OP_DX,
        OP_START_F,
        OP_START_KM,
        OP_MAIN1,
        OP_MAIN2,
        OP_PRESENT
    } op_t;

    typedef struct packed {
        op_t op;
    } asl_cmd_t;

    typedef struct packed {
        logic div_busy;
    } asl_status_t;

endpackage

[sv/asl_div.sv]
// ----------------------------------------------------------------------------
// asl_div
// Radix-2 restoring divider, one quotient bit per cycle; zero divisor gives
// all ones.
// ----------------------------------------------------------------------------
module asl_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [32:0] sub;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[31:0], quo_reg[31]};
        sub       = trial - {1'b0, den_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!sub[32])
            begin
                rem_next = sub;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    // a zero divisor yields all ones from the restoring loop itself
    assign quotient = quo_reg;
endmodule

[sv/asl_datapath.sv]
// ----------------------------------------------------------------------------
// asl_datapath
// Configuration registers, filter state, shared multiplier and divider.
// ----------------------------------------------------------------------------
module asl_datapath #(
    parameter int unsigned SAMPLE_WIDTH = asl_pkg::SAMPLE_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic [SAMPLE_WIDTH-1:0]  sample,
    input  asl_pkg::asl_cmd_t        cmd,
    output asl_pkg::asl_status_t     status,
    output logic [15:0]              filtered,
    output logic [31:0]              main_gain
);
    import asl_pkg::*;

    logic [13:0] min_freq_reg, max_freq_reg, deriv_cutoff_reg;
    logic [15:0] inv_beta_reg, sample_rate_reg;
    logic [23:0] max_slew_reg;

    logic [31:0] last_reg, d1_reg, d2_reg, m1_reg, m2_reg, prev_reg;
    logic [31:0] x_reg, scaled_reg, km_reg, dx_reg;
    logic [15:0] filtered_reg;

    logic        div_start;
    logic [31:0] div_a, div_b, div_q;
    logic        div_busy;

    logic [31:0] iv_ext, iv_scaled, x_ext;
    logic [31:0] s_diff, neg_diff, limited;
    logic [31:0] stage_s, stage_x, stage_prod, stage_out;
    logic [31:0] adx, fsum, fclamp, mf, q;

    asl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign status.div_busy = div_busy;

    assign iv_ext    = {{16{cfg_data[15]}}, cfg_data[15:0]};
    assign iv_scaled = iv_ext << PT_SHIFT;
    assign x_ext     = {{(32-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};

    // slew limit against the previous limited input; the divider holds the limit
    always_comb
    begin
        s_diff   = x_reg - last_reg;
        neg_diff = 32'd0 - s_diff;
        limited  = x_reg;
        if (div_q != 32'd0)
        begin
            if ($signed(s_diff) > $signed(div_q))
                limited = last_reg + div_q;
            else if ($signed(neg_diff) > $signed(div_q))
                limited = last_reg - div_q;
        end
    end

    // one shared filter stage; the divider holds the gain of the current pair
    always_comb
    begin
        case (cmd.op)
            OP_DERIV1:
            begin
                stage_s = d1_reg;
                stage_x = scaled_reg;
            end
            OP_DERIV2:
            begin
                stage_s = d2_reg;
                stage_x = d1_reg;
            end
            OP_MAIN1:
            begin
                stage_s = m1_reg;
                stage_x = scaled_reg;
            end
            default:
            begin
                stage_s = m2_reg;
                stage_x = m1_reg;
            end
        endcase
        stage_prod = div_q * (stage_x - stage_s);
        stage_out  = stage_s + 32'($signed(stage_prod) >>> K_SHIFT);
    end

    assign adx    = dx_reg[31] ? 32'd0 - dx_reg : dx_reg;
    assign fsum   = {18'd0, min_freq_reg} + div_q;
    assign fclamp = (fsum > {18'd0, max_freq_reg}) ? {18'd0, max_freq_reg} : fsum;
    assign mf     = m2_reg;
    assign q      = mf[31] ? 32'd0 - ((32'd0 - mf) >> PT_SHIFT) : mf >> PT_SHIFT;

    always_comb
    begin
        div_start = 1'b0;
        div_a     = 32'd0;
        div_b     = {16'd0, sample_rate_reg};
        case (cmd.op)
            OP_START_LIM:
            begin
                div_start = 1'b1;
                div_a     = {8'd0, max_slew_reg};
            end
            OP_START_KD:
            begin
                div_start = 1'b1;
                div_a     = {18'd0, deriv_cutoff_reg} * TWO_PI_Q16;
            end
            OP_START_F:
            begin
                div_start = 1'b1;
                div_a     = adx;
                div_b     = {16'd0, inv_beta_reg} << PT_SHIFT;
            end
            OP_START_KM:
            begin
                div_start = 1'b1;
                div_a     = fclamp * TWO_PI_Q16;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_freq_reg     <= 14'd1;
            max_freq_reg     <= 14'd50;
            inv_beta_reg     <= 16'd100;
            sample_rate_reg  <= 16'd500;
            deriv_cutoff_reg <= 14'd10;
            max_slew_reg     <= 24'd0;
            last_reg         <= 32'd0;
            d1_reg           <= 32'd0;
            d2_reg           <= 32'd0;
            m1_reg           <= 32'd0;
            m2_reg           <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_FREQ:     min_freq_reg     <= cfg_data[13:0];
                REG_MAX_FREQ:     max_freq_reg     <= cfg_data[13:0];
                REG_INV_BETA:     inv_beta_reg     <= cfg_data[15:0];
                REG_SAMPLE_RATE:  sample_rate_reg  <= cfg_data[15:0];
                REG_DERIV_CUTOFF: deriv_cutoff_reg <= cfg_data[13:0];
                REG_MAX_SLEW:     max_slew_reg     <= cfg_data[23:0];
                REG_INIT_VALUE:
                begin
                    last_reg <= iv_ext;
                    d1_reg   <= iv_scaled;
                    d2_reg   <= iv_scaled;
                    m1_reg   <= iv_scaled;
                    m2_reg   <= iv_scaled;
                end
                default: ;
            endcase
        end
        else
        begin
            case (cmd.op)
                OP_LIMIT:  last_reg <= limited;
                OP_DERIV1: d1_reg   <= stage_out;
                OP_DERIV2: d2_reg   <= stage_out;
                OP_MAIN1:  m1_reg   <= stage_out;
                OP_MAIN2:  m2_reg   <= stage_out;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:  x_reg      <= x_ext;
            OP_LIMIT:    scaled_reg <= limited << PT_SHIFT;
            OP_DERIV2:   prev_reg   <= d2_reg;
            OP_DX:       dx_reg     <= (d2_reg - prev_reg) * {16'd0, sample_rate_reg};
            OP_PRESENT:
            begin
                // the divider still holds the main gain here
                filtered_reg <= q[15:0];
                km_reg       <= div_q;
            end
            default: ;
        endcase
    end

    assign filtered  = filtered_reg;
    assign main_gain = km_reg;
endmodule

[sv/asl_ctrl.sv]
// ----------------------------------------------------------------------------
// asl_ctrl
// Sequencer for one item: divisions, slew limit, four filter stages.
// ----------------------------------------------------------------------------
module asl_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  asl_pkg::asl_status_t  status,
    output asl_pkg::asl_cmd_t     cmd
);
    import asl_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        in_stall       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DIV_LIM;
                end
            end
            ST_DIV_LIM:
            begin
                cmd.op     = OP_START_LIM;
                state_next = ST_LIMIT;
            end
            ST_LIMIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_LIMIT;
                    state_next = ST_DIV_KD;
                end
            end
            ST_DIV_KD:
            begin
                cmd.op     = OP_START_KD;
                state_next = ST_DERIV1;
            end
            ST_DERIV1:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_DERIV1;
                    state_next = ST_DERIV2;
                end
            end
            ST_DERIV2:
            begin
                cmd.op     = OP_DERIV2;
                state_next = ST_DX;
            end
            ST_DX:
            begin
                cmd.op     = OP_DX;
                state_next = ST_DIV_F;
            end
            ST_DIV_F:
            begin
                cmd.op     = OP_START_F;
                state_next = ST_DIV_KM;
            end
            ST_DIV_KM:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_START_KM;
                    state_next = ST_MAIN1;
                end
            end
            ST_MAIN1:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_MAIN1;
                    state_next = ST_MAIN2;
                end
            end
            ST_MAIN2:
            begin
                cmd.op     = OP_MAIN2;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_PRESENT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
endmodule

[sv/adaptive_speed_lowpass_filter.sv]
// ----------------------------------------------------------------------------
// adaptive_speed_lowpass_filter
// Slew limited, speed adaptive two-pole low-pass filter.
//
//   channel   signals                          direction
//   input     in_valid, in_stall, sample       in
//   output    out_valid, out_stall, filtered,  out
//             main_gain
//   config    cfg_valid, cfg_ready, cfg_index, in
//             cfg_data
//
// Each item runs four serial divisions of 32 steps, and a new item is
// taken only once the result of the last one has been presented.
// Reset loads the register defaults and clears all filter state.
// A result waits in the output register; the next item is taken while it
// is held, and the sequencer only stalls at its end if it is still unread.
// ----------------------------------------------------------------------------
module adaptive_speed_lowpass_filter #(
    parameter int unsigned SAMPLE_WIDTH = asl_pkg::SAMPLE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [15:0]             filtered,
    output logic [31:0]             main_gain,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data
);
    import asl_pkg::*;

    asl_cmd_t    cmd;
    asl_status_t status;

    assign cfg_ready = 1'b1;

    asl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    asl_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .status    (status),
        .filtered  (filtered),
        .main_gain (main_gain)
    );
endmodule

[tb/adaptive_speed_lowpass_filter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_speed_lowpass_filter_checker
// Watches the sample, result and register channels of the filter, keeps its
// own copy of registers and filter state, predicts each result and compares
// it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module adaptive_speed_lowpass_filter_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] sample,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] filtered,
    input  logic [31:0] main_gain,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);
    import asl_pkg::*;

    typedef struct packed {
        logic [15:0] filtered;
        logic [31:0] main_gain;
    } filter_result_t;

    filter_result_t pending_results[$];

    logic [31:0] min_freq, max_freq, inverse_beta, sample_rate;
    logic [31:0] deriv_cutoff, max_slew, initial_value;
    logic [31:0] last_limited, deriv_one, deriv_two, main_one, main_two;

    function automatic logic [31:0] divide(logic [31:0] a, logic [31:0] b);
        return (b == 0) ? 32'hFFFF_FFFF : a / b;
    endfunction

    function automatic logic [31:0] pt1_update(logic [31:0] s, logic [31:0] x,
                                               logic [31:0] k);
        logic signed [31:0] prod;
        prod = k * (x - s);
        return s + 32'(prod >>> K_SHIFT);
    endfunction

    task automatic reload_state();
        logic [31:0] iv;
        iv = {{16{initial_value[15]}}, initial_value[15:0]};
        last_limited = iv;
        deriv_one = iv << PT_SHIFT;
        deriv_two = iv << PT_SHIFT;
        main_one = iv << PT_SHIFT;
        main_two = iv << PT_SHIFT;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic filter_sample(logic [15:0] raw);
        logic [31:0] x, lim, limited, diff, scaled, kd, prev, dx, adx, fmain, kmain, q;
        filter_result_t res;
        x = {{16{raw[15]}}, raw};
        lim = divide(max_slew, sample_rate);
        limited = x;
        if (lim != 0)
        begin
            diff = x - last_limited;
            if ($signed(diff) > $signed(lim))
                limited = last_limited + lim;
            else if ($signed(-diff) > $signed(lim))
                limited = last_limited - lim;
        end
        scaled = limited << PT_SHIFT;
        kd = divide(deriv_cutoff * TWO_PI_Q16, sample_rate);
        prev = deriv_two;
        deriv_one = pt1_update(deriv_one, scaled, kd);
        deriv_two = pt1_update(deriv_two, deriv_one, kd);
        dx = (deriv_two - prev) * sample_rate;
        adx = dx[31] ? -dx : dx;
        fmain = min_freq + divide(adx, inverse_beta << PT_SHIFT);
        if (fmain > max_freq)
            fmain = max_freq;
        kmain = divide(fmain * TWO_PI_Q16, sample_rate);
        main_one = pt1_update(main_one, scaled, kmain);
        main_two = pt1_update(main_two, main_one, kmain);
        last_limited = limited;
        q = main_two[31] ? -((-main_two) >> PT_SHIFT) : main_two >> PT_SHIFT;
        res.filtered = q[15:0];
        res.main_gain = kmain;
        pending_results.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            pending_results.delete();
            pending_count = 0;
            min_freq = 1;
            max_freq = 50;
            inverse_beta = 100;
            sample_rate = 500;
            deriv_cutoff = 10;
            max_slew = 0;
            initial_value = 0;
            reload_state();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result", {16'd0, filtered}, 32'd0);
                end
                else
                begin
                    filter_result_t want;
                    want = pending_results.pop_front();
                    if (filtered !== want.filtered)
                        report_mismatch("filtered", {16'd0, filtered},
                                        {16'd0, want.filtered});
                    if (main_gain !== want.main_gain)
                        report_mismatch("main_gain", main_gain, want.main_gain);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_FREQ:     min_freq = cfg_data & 32'h3FFF;
                    REG_MAX_FREQ:     max_freq = cfg_data & 32'h3FFF;
                    REG_INV_BETA:     inverse_beta = cfg_data & 32'hFFFF;
                    REG_SAMPLE_RATE:  sample_rate = cfg_data & 32'hFFFF;
                    REG_DERIV_CUTOFF: deriv_cutoff = cfg_data & 32'h3FFF;
                    REG_MAX_SLEW:     max_slew = cfg_data & 32'hFF_FFFF;
                    REG_INIT_VALUE:
                    begin
                        initial_value = cfg_data & 32'hFFFF;
                        reload_state();
                    end
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                filter_sample(sample);
            pending_count = pending_results.size();
        end
    end

endmodule

[tb/adaptive_speed_lowpass_filter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_speed_lowpass_filter_tb
// Drives samples and register writes into the filter under several idle and
// stall mixes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module adaptive_speed_lowpass_filter_tb;
    import asl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] sample;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] filtered;
    logic [31:0] main_gain;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending_count;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_receiver;
    int idle_cycles;

    adaptive_speed_lowpass_filter dut (.*);

    adaptive_speed_lowpass_filter_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stall, with an optional long hold
    always @(posedge clk)
    begin
        if (hold_receiver)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("adaptive_speed_lowpass_filter_tb failed");
            $finish;
        end
    end

    task automatic push_sample(logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(200)) - 100);
            2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(4000));
        endcase
    endfunction

    task automatic run_random(int count);
        logic [15:0] base;
        base = 16'($urandom);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(7) == 0)
                base = random_sample();
            push_sample(base + 16'(int'($urandom_range(64)) - 32));
        end
    endtask

    task automatic set_config(logic [31:0] minf, logic [31:0] maxf, logic [31:0] ib,
                              logic [31:0] sr, logic [31:0] dc, logic [31:0] slew,
                              logic [31:0] iv);
        write_reg(REG_MIN_FREQ, minf);
        write_reg(REG_MAX_FREQ, maxf);
        write_reg(REG_INV_BETA, ib);
        write_reg(REG_SAMPLE_RATE, sr);
        write_reg(REG_DERIV_CUTOFF, dc);
        write_reg(REG_MAX_SLEW, slew);
        write_reg(REG_INIT_VALUE, iv);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_stall = 1'b0;
        hold_receiver = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes under reset settings
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        wait_drained();

        // slew limiting active, extreme registers
        set_config(0, 10000, 1, 1, 10000, 32'h00FF_FFFF, 32'h0000_8000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0123);
        wait_drained();
        set_config(10000, 10000, 65535, 65535, 0, 100000, 32'h0000_7FFF);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h0000);
        wait_drained();
        // zero divisors
        set_config(16383, 16383, 0, 0, 16383, 32'h00FF_FFFF, 0);
        push_sample(16'h1234);
        push_sample(16'hEDCC);
        wait_drained();
        set_config(5, 2000, 3, 1000, 200, 50000, 32'h0000_FF00);
        push_sample(16'h4000);
        push_sample(16'hC000);
        wait_drained();

        // long receiver hold while the sender keeps offering items
        set_config(1, 50, 100, 500, 10, 0, 0);
        hold_receiver = 1'b1;
        fork
            run_random(20);
            begin
                repeat (3000) @(posedge clk);
                hold_receiver = 1'b0;
            end
        join
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            case (phase)
                0: set_config(1, 50, 100, 500, 10, 0, 0);
                1: set_config(0, 0, 1, 1, 0, 32'h00FF_FFFF, 32'h0000_7FFF);
                2: set_config(10000, 10000, 65535, 65535, 10000, 0, 32'h0000_8000);
                3: set_config(10, 500, 10, 1000, 50, 300000, 32'h0000_0100);
                4: set_config($urandom_range(10000), $urandom_range(10000),
                              $urandom_range(65535), $urandom_range(65535),
                              $urandom_range(10000), $urandom, $urandom);
                default: set_config($urandom_range(100), $urandom_range(100, 10000),
                                    $urandom_range(1, 500), $urandom_range(50, 2000),
                                    $urandom_range(100), $urandom_range(200000),
                                    $urandom);
            endcase
            run_random(150);
            wait_drained();
        end

        if (fail_count == 0)
            $display("adaptive_speed_lowpass_filter_tb passed");
        else
            $display("adaptive_speed_lowpass_filter_tb failed");
        $finish;
    end

endmodule
